// File: design/gvp_pkg.sv
// ----------------------------------------------------------------------------
// gvp_pkg: shared types and constants for the generational handle pool
// Sizes, slot pointer helpers, action and status codes, sequencer states and
// the memory port structs used between the top level and the slot store.
// ----------------------------------------------------------------------------
package gvp_pkg;

  localparam int Capacity = 1024;
  localparam int IdxW     = $clog2(Capacity);
  localparam int PtrW     = IdxW + 1;
  localparam int CntW     = $clog2(Capacity + 1);
  localparam int KeyW     = 32;
  localparam int ValW     = 32;
  localparam int ActW     = 3;
  localparam int StatW    = 2;

  localparam logic [PtrW-1:0] NilPtr = '1;

  typedef enum logic [ActW-1:0] {
    ActAlloc    = 3'd0,
    ActFree     = 3'd1,
    ActRead     = 3'd2,
    ActWrite    = 3'd3,
    ActIterHead = 3'd4,
    ActIterNext = 3'd5
  } action_e;

  typedef enum logic [StatW-1:0] {
    StOk      = 2'd0,
    StFull    = 2'd1,
    StInvalid = 2'd2,
    StEnd     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    SIdle,
    SExec,
    SAllocLink,
    SFreeFin,
    SIterFetch,
    SResp
  } state_e;

  typedef struct packed {
    logic            en;
    logic [IdxW-1:0] addr;
    logic [KeyW-1:0] data;
  } key_wr_t;

  typedef struct packed {
    logic            en;
    logic [IdxW-1:0] addr;
    logic [PtrW-1:0] data;
  } ptr_wr_t;

  typedef struct packed {
    logic            en;
    logic [IdxW-1:0] addr;
    logic [ValW-1:0] data;
  } val_wr_t;

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [PtrW-1:0] next;
    logic [PtrW-1:0] prev;
    logic [ValW-1:0] value;
  } slot_rd_t;

  typedef struct packed {
    status_e         status;
    logic [KeyW-1:0] out_key;
    logic [IdxW-1:0] out_index;
    logic [ValW-1:0] read_data;
    logic [CntW-1:0] live_count;
  } result_t;

  function automatic logic ptr_valid(input logic [PtrW-1:0] ptr);
    return ptr < PtrW'(Capacity);
  endfunction

endpackage

// File: design/gvp_if.sv
// ----------------------------------------------------------------------------
// gvp channels: request and response word channels
// Valid/ready handshake; a word moves on a clock edge with both high.
// ----------------------------------------------------------------------------
interface gvp_req_if;
  import gvp_pkg::*;

  logic                valid;
  logic                ready;
  logic [ActW-1:0]     action;
  logic [KeyW-1:0]     handle_key;
  logic [IdxW-1:0]     handle_index;
  logic [ValW-1:0]     write_data;

  modport source (output valid, action, handle_key, handle_index, write_data,
                  input ready);
  modport sink   (input valid, action, handle_key, handle_index, write_data,
                  output ready);
endinterface

interface gvp_rsp_if;
  import gvp_pkg::*;

  logic                valid;
  logic                ready;
  logic [StatW-1:0]    status;
  logic [KeyW-1:0]     out_key;
  logic [IdxW-1:0]     out_index;
  logic [ValW-1:0]     read_data;
  logic [CntW-1:0]     live_count;

  modport source (output valid, status, out_key, out_index, read_data, live_count,
                  input ready);
  modport sink   (input valid, status, out_key, out_index, read_data, live_count,
                  output ready);
endinterface

// File: design/gvp_slot_store.sv
// ----------------------------------------------------------------------------
// gvp_slot_store: per-slot key, link and value memories
// One shared read address with registered read data, one write port each.
// ----------------------------------------------------------------------------
module gvp_slot_store (
  input  logic                   clk_i,
  input  logic [gvp_pkg::IdxW-1:0] rd_addr_i,
  input  gvp_pkg::key_wr_t       key_wr_i,
  input  gvp_pkg::ptr_wr_t       next_wr_i,
  input  gvp_pkg::ptr_wr_t       prev_wr_i,
  input  gvp_pkg::val_wr_t       val_wr_i,
  output gvp_pkg::slot_rd_t      rd_o
);
  import gvp_pkg::*;

  logic [KeyW-1:0] key_mem  [Capacity];
  logic [PtrW-1:0] next_mem [Capacity];
  logic [PtrW-1:0] prev_mem [Capacity];
  logic [ValW-1:0] val_mem  [Capacity];

  always_ff @(posedge clk_i) begin
    if (key_wr_i.en) begin
      key_mem[key_wr_i.addr] <= key_wr_i.data;
    end
    if (next_wr_i.en) begin
      next_mem[next_wr_i.addr] <= next_wr_i.data;
    end
    if (prev_wr_i.en) begin
      prev_mem[prev_wr_i.addr] <= prev_wr_i.data;
    end
    if (val_wr_i.en) begin
      val_mem[val_wr_i.addr] <= val_wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_o.key   <= key_mem[rd_addr_i];
    rd_o.next  <= next_mem[rd_addr_i];
    rd_o.prev  <= prev_mem[rd_addr_i];
    rd_o.value <= val_mem[rd_addr_i];
  end

endmodule

// File: design/generational_handle_pool.sv
// ----------------------------------------------------------------------------
// generational_handle_pool: fixed-capacity slot map with generational handles
// Sequencing: read, write, iterate-first, a rejected request and an allocate
//   into an empty live list pass through SExec and SResp; a good free, an
//   allocate onto a non-empty live list and iterate-next with a successor also
//   pass through SFreeFin, SAllocLink or SIterFetch (the slot clear and free
//   list push, the second link write or the second read). One request at a time,
//   set by the single read port of the slot memories and the link writes; ready
//   stays low until the response word has moved into the output register.
// Reset: free list, live list and cursor go null, high-water mark and live
//   count to zero, key counter to one; slot memories are not cleared.
// ----------------------------------------------------------------------------
module generational_handle_pool (
  input  logic       clk_i,
  input  logic       rst_ni,
  gvp_req_if.sink    req_i,
  gvp_rsp_if.source  rsp_o
);
  import gvp_pkg::*;

  // Sequencer and latched request word
  state_e          state_q, state_d;
  action_e         act_q;
  logic [KeyW-1:0] key_q;
  logic [IdxW-1:0] idx_q;
  logic [ValW-1:0] wdata_q;
  logic [IdxW-1:0] slot_q, slot_d;

  // Pool bookkeeping
  logic [PtrW-1:0] free_head_q, free_head_d;
  logic [PtrW-1:0] live_head_q, live_head_d;
  logic [PtrW-1:0] high_water_q, high_water_d;
  logic [KeyW-1:0] key_ctr_q, key_ctr_d;
  logic [CntW-1:0] count_q, count_d;
  logic [PtrW-1:0] cursor_q, cursor_d;

  // Result staging and output register
  result_t         res_q, res_d;
  result_t         out_q;
  logic            out_valid_q;

  // Slot store ports
  logic [IdxW-1:0] rd_addr;
  key_wr_t         key_wr;
  ptr_wr_t         next_wr;
  ptr_wr_t         prev_wr;
  val_wr_t         val_wr;
  slot_rd_t        rd;

  logic            accept;
  logic            handle_ok;
  logic            alloc_take;
  logic            alloc_from_free;
  logic [IdxW-1:0] alloc_slot;
  logic [KeyW-1:0] key_ctr_inc;
  logic            out_free;

  gvp_slot_store u_store (
    .clk_i     (clk_i),
    .rd_addr_i (rd_addr),
    .key_wr_i  (key_wr),
    .next_wr_i (next_wr),
    .prev_wr_i (prev_wr),
    .val_wr_i  (val_wr),
    .rd_o      (rd)
  );

  assign req_i.ready = (state_q == SIdle);
  assign accept      = req_i.valid && req_i.ready;
  assign out_free    = !out_valid_q || rsp_o.ready;

  // A handle is good when its key is nonzero, its slot has been handed out at
  // least once and the stored key still matches.
  assign handle_ok = (key_q != '0) && ({1'b0, idx_q} < high_water_q) && (rd.key == key_q);

  // Allocation source: free list first, else the high-water mark
  assign alloc_from_free = ptr_valid(free_head_q);
  assign alloc_take      = alloc_from_free || (high_water_q < PtrW'(Capacity));
  assign alloc_slot      = alloc_from_free ? free_head_q[IdxW-1:0] : high_water_q[IdxW-1:0];
  assign key_ctr_inc     = key_ctr_q + KeyW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= SIdle;
      free_head_q  <= NilPtr;
      live_head_q  <= NilPtr;
      high_water_q <= '0;
      key_ctr_q    <= KeyW'(1);
      count_q      <= '0;
      cursor_q     <= NilPtr;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      free_head_q  <= free_head_d;
      live_head_q  <= live_head_d;
      high_water_q <= high_water_d;
      key_ctr_q    <= key_ctr_d;
      count_q      <= count_d;
      cursor_q     <= cursor_d;
      if (state_q == SResp && out_free) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q   <= action_e'(req_i.action);
      key_q   <= req_i.handle_key;
      idx_q   <= req_i.handle_index;
      wdata_q <= req_i.write_data;
    end
    slot_q <= slot_d;
    res_q  <= res_d;
    if (state_q == SResp && out_free) begin
      out_q <= res_q;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.status     = out_q.status;
  assign rsp_o.out_key    = out_q.out_key;
  assign rsp_o.out_index  = out_q.out_index;
  assign rsp_o.read_data  = out_q.read_data;
  assign rsp_o.live_count = out_q.live_count;

  always_comb begin
    state_d      = state_q;
    slot_d       = slot_q;
    free_head_d  = free_head_q;
    live_head_d  = live_head_q;
    high_water_d = high_water_q;
    key_ctr_d    = key_ctr_q;
    count_d      = count_q;
    cursor_d     = cursor_q;
    res_d        = res_q;
    rd_addr      = idx_q;
    key_wr       = '0;
    next_wr      = '0;
    prev_wr      = '0;
    val_wr       = '0;

    case (state_q)
      SIdle: begin
        // Present the first read address in the accept cycle
        case (action_e'(req_i.action))
          ActAlloc:    rd_addr = free_head_q[IdxW-1:0];
          ActIterHead: rd_addr = live_head_q[IdxW-1:0];
          ActIterNext: rd_addr = cursor_q[IdxW-1:0];
          default:     rd_addr = req_i.handle_index;
        endcase
        if (accept) begin
          state_d = SExec;
        end
      end

      SExec: begin
        res_d.status     = StInvalid;
        res_d.out_key    = '0;
        res_d.out_index  = '0;
        res_d.read_data  = '0;
        res_d.live_count = count_q;
        state_d          = SResp;
        case (act_q)
          ActAlloc: begin
            if (alloc_take) begin
              if (alloc_from_free) begin
                free_head_d = rd.next;
              end else begin
                high_water_d = high_water_q + PtrW'(1);
              end
              key_wr  = '{en: 1'b1, addr: alloc_slot, data: key_ctr_q};
              val_wr  = '{en: 1'b1, addr: alloc_slot, data: '0};
              next_wr = '{en: 1'b1, addr: alloc_slot, data: live_head_q};
              prev_wr = '{en: 1'b1, addr: alloc_slot, data: NilPtr};
              key_ctr_d = (key_ctr_inc == '0) ? KeyW'(1) : key_ctr_inc;
              count_d   = count_q + CntW'(1);
              slot_d    = alloc_slot;
              res_d.status     = StOk;
              res_d.out_key    = key_ctr_q;
              res_d.out_index  = alloc_slot;
              res_d.live_count = count_q + CntW'(1);
              // Back-link the old head in SAllocLink: one prev write port
              if (ptr_valid(live_head_q)) begin
                state_d = SAllocLink;
              end else begin
                live_head_d = {1'b0, alloc_slot};
              end
            end else begin
              res_d.status = StFull;
            end
          end
          ActFree: begin
            if (handle_ok) begin
              // Unlink from the live list; the slot itself is recycled next cycle
              if (live_head_q == {1'b0, idx_q}) begin
                live_head_d = rd.next;
              end else if (ptr_valid(rd.prev)) begin
                next_wr = '{en: 1'b1, addr: rd.prev[IdxW-1:0], data: rd.next};
              end
              if (ptr_valid(rd.next)) begin
                prev_wr = '{en: 1'b1, addr: rd.next[IdxW-1:0], data: rd.prev};
              end
              state_d = SFreeFin;
            end
          end
          ActRead: begin
            if (handle_ok) begin
              res_d.status    = StOk;
              res_d.read_data = rd.value;
            end
          end
          ActWrite: begin
            if (handle_ok) begin
              val_wr       = '{en: 1'b1, addr: idx_q, data: wdata_q};
              res_d.status = StOk;
            end
          end
          ActIterHead: begin
            cursor_d = live_head_q;
            if (ptr_valid(live_head_q)) begin
              res_d.status    = StOk;
              res_d.out_key   = rd.key;
              res_d.out_index = live_head_q[IdxW-1:0];
              res_d.read_data = rd.value;
            end else begin
              res_d.status = StEnd;
            end
          end
          ActIterNext: begin
            // Step to the successor, then fetch its key and value
            if (ptr_valid(cursor_q) && ptr_valid(rd.next)) begin
              cursor_d = rd.next;
              rd_addr  = rd.next[IdxW-1:0];
              state_d  = SIterFetch;
            end else begin
              cursor_d     = NilPtr;
              res_d.status = StEnd;
            end
          end
          default: begin
            res_d.status = StInvalid;
          end
        endcase
      end

      SAllocLink: begin
        prev_wr     = '{en: 1'b1, addr: live_head_q[IdxW-1:0], data: {1'b0, slot_q}};
        live_head_d = {1'b0, slot_q};
        state_d     = SResp;
      end

      SFreeFin: begin
        // Clear the slot and push it onto the free list
        key_wr      = '{en: 1'b1, addr: idx_q, data: '0};
        val_wr      = '{en: 1'b1, addr: idx_q, data: '0};
        next_wr     = '{en: 1'b1, addr: idx_q, data: free_head_q};
        prev_wr     = '{en: 1'b1, addr: idx_q, data: NilPtr};
        free_head_d = {1'b0, idx_q};
        count_d     = count_q - CntW'(1);
        if (cursor_q == {1'b0, idx_q}) begin
          cursor_d = NilPtr;
        end
        res_d.status     = StOk;
        res_d.out_key    = '0;
        res_d.out_index  = '0;
        res_d.read_data  = '0;
        res_d.live_count = count_q - CntW'(1);
        state_d          = SResp;
      end

      SIterFetch: begin
        res_d.status     = StOk;
        res_d.out_key    = rd.key;
        res_d.out_index  = cursor_q[IdxW-1:0];
        res_d.read_data  = rd.value;
        res_d.live_count = count_q;
        state_d          = SResp;
      end

      SResp: begin
        // Hold until the output register can take the word
        if (out_free) begin
          state_d = SIdle;
        end
      end

      default: begin
        state_d = SIdle;
      end
    endcase
  end

endmodule
